### hdl/ile_pkg.sv
// Package for the indexed list engine: sizes, operation and status codes,
// sequencer states and the structs passed between the sequencer and the top.
// No dependencies.
package ile_pkg;

  // Capacity and stored entry width
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed port field widths
  localparam int OP_W       = 3;
  localparam int POS_W      = 4;
  localparam int VALUE_W    = 32;
  localparam int DATA_OUT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_INSERT  = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_REPLACE = 3'd4,
    OP_READ    = 3'd5,
    OP_TOP     = 3'd6,
    OP_CLEAR   = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CAPT,
    S_SH_RD,
    S_SH_WR,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

### hdl/ile_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ile_ctl.sv
// Sequencer of the indexed list engine: decodes an operation, walks the
// shift cursor through the entry RAM and keeps the entry count.
// Depends on ile_pkg.
module ile_ctl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ile_pkg::OP_W-1:0]       op_i,
  input  logic [ile_pkg::POS_W-1:0]      position_i,
  input  logic [ile_pkg::VALUE_W-1:0]    value_i,
  output ile_pkg::ram_req_t              ram_req_o,
  input  logic [ile_pkg::DATA_W-1:0]     ram_rdata_i,
  output logic                           done_o,
  input  logic                           res_take_i,
  output ile_pkg::result_t               res_o
);

  ile_pkg::state_e                  state_q, state_d;
  ile_pkg::op_e                     op_q, op_d;
  logic [ile_pkg::CNT_W-1:0]        pos_q, pos_d;
  logic [ile_pkg::DATA_W-1:0]       val_q, val_d;
  logic [ile_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [ile_pkg::CNT_W-1:0]        cur_q, cur_d;
  logic [ile_pkg::DATA_W-1:0]       data_q, data_d;
  ile_pkg::status_e                 status_q, status_d;

  logic [ile_pkg::CNT_W-1:0]        in_pos, clamp_pos, cnt_m1, nxt;
  logic [ile_pkg::CNT_W:0]          nxt_p1;
  logic                             full, empty, out_rng, more, is_ins;

  // Shared cursor unit: one step up or down plus an end compare chosen by direction
  assign is_ins    = (op_q == ile_pkg::OP_INSERT);
  assign nxt       = is_ins ? (cur_q - 1'b1) : (cur_q + 1'b1);
  assign nxt_p1    = {1'b0, nxt} + 1'b1;
  assign more      = is_ins ? (nxt > pos_q) : (nxt_p1 < {1'b0, cnt_q});

  assign in_pos    = ile_pkg::CNT_W'(position_i);
  assign clamp_pos = (in_pos > cnt_q) ? cnt_q : in_pos;
  assign cnt_m1    = cnt_q - 1'b1;
  assign full      = (cnt_q == ile_pkg::CNT_W'(ile_pkg::DEPTH));
  assign empty     = (cnt_q == '0);
  assign out_rng   = (in_pos >= cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ile_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    cur_q    <= cur_d;
    data_q   <= data_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    pos_d    = pos_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    data_d   = data_q;
    status_d = status_q;

    ram_req_o       = '0;
    ram_req_o.waddr = cur_q[ile_pkg::IDX_W-1:0];
    ram_req_o.raddr = cur_q[ile_pkg::IDX_W-1:0];
    ram_req_o.wdata = val_q;
    in_ready_o      = 1'b0;
    done_o          = 1'b0;

    unique case (state_q)
      ile_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = ile_pkg::op_e'(op_i);
          pos_d    = in_pos;
          val_d    = ile_pkg::DATA_W'(value_i);
          data_d   = '0;
          status_d = ile_pkg::STAT_OK;
          state_d  = ile_pkg::S_DONE;
          unique case (ile_pkg::op_e'(op_i)) inside
            ile_pkg::OP_PUSH: begin
              if (full) begin
                status_d = ile_pkg::STAT_FULL;
              end else begin
                cur_d   = cnt_q;
                state_d = ile_pkg::S_WRITE;
              end
            end
            ile_pkg::OP_POP, ile_pkg::OP_TOP: begin
              if (empty) begin
                status_d = ile_pkg::STAT_EMPTY;
              end else begin
                cur_d   = cnt_m1;
                state_d = ile_pkg::S_READ;
              end
            end
            ile_pkg::OP_INSERT: begin
              if (full) begin
                status_d = ile_pkg::STAT_FULL;
              end else begin
                pos_d   = clamp_pos;
                cur_d   = cnt_q;
                state_d = (cnt_q > clamp_pos) ? ile_pkg::S_SH_RD : ile_pkg::S_WRITE;
              end
            end
            ile_pkg::OP_REMOVE, ile_pkg::OP_READ: begin
              if (out_rng) begin
                status_d = ile_pkg::STAT_EMPTY;
              end else begin
                cur_d   = in_pos;
                state_d = ile_pkg::S_READ;
              end
            end
            ile_pkg::OP_REPLACE: begin
              if (out_rng) begin
                status_d = ile_pkg::STAT_EMPTY;
              end else begin
                cur_d   = in_pos;
                state_d = ile_pkg::S_WRITE;
              end
            end
            ile_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
              state_d = ile_pkg::S_DONE;
            end
          endcase
        end
      end
      ile_pkg::S_READ: begin
        state_d = ile_pkg::S_CAPT;
      end
      ile_pkg::S_CAPT: begin
        data_d = ram_rdata_i;
        // Remove shifts only when an entry sits above the cursor
        if (op_q == ile_pkg::OP_REMOVE && nxt < cnt_q) begin
          state_d = ile_pkg::S_SH_RD;
        end else begin
          if (op_q == ile_pkg::OP_POP || op_q == ile_pkg::OP_REMOVE) begin
            cnt_d = cnt_m1;
          end
          state_d = ile_pkg::S_DONE;
        end
      end
      ile_pkg::S_SH_RD: begin
        ram_req_o.raddr = nxt[ile_pkg::IDX_W-1:0];
        state_d         = ile_pkg::S_SH_WR;
      end
      ile_pkg::S_SH_WR: begin
        // Move the neighbor entry into the cursor slot
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = ram_rdata_i;
        cur_d           = nxt;
        if (more) begin
          state_d = ile_pkg::S_SH_RD;
        end else if (is_ins) begin
          state_d = ile_pkg::S_WRITE;
        end else begin
          cnt_d   = cnt_m1;
          state_d = ile_pkg::S_DONE;
        end
      end
      ile_pkg::S_WRITE: begin
        ram_req_o.we = 1'b1;
        if (op_q == ile_pkg::OP_PUSH || op_q == ile_pkg::OP_INSERT) begin
          cnt_d = cnt_q + 1'b1;
        end
        state_d = ile_pkg::S_DONE;
      end
      ile_pkg::S_DONE: begin
        done_o = 1'b1;
        if (res_take_i) begin
          state_d = ile_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ile_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.data   = data_q;
  assign res_o.status = status_q;
  assign res_o.count  = cnt_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ile_pkg::CNT_W'(ile_pkg::DEPTH))
    else $error("entry count above capacity");

  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ile_pkg::S_IDLE || state_q == ile_pkg::S_DONE) |-> !ram_req_o.we)
    else $error("RAM write outside an operation");

  a_cnt_stable_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ile_pkg::S_DONE) |=> $stable(cnt_q))
    else $error("count changed after result formed");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == ile_pkg::STAT_FULL) |->
      (op_q == ile_pkg::OP_PUSH || op_q == ile_pkg::OP_INSERT))
    else $error("full status on an operation that does not add");
`endif

endmodule

### hdl/indexed_list_engine.sv
// Top level of the indexed list engine: entry RAM, sequencer and the
// result register. Depends on ile_pkg, ile_ram and ile_ctl.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i/in_ready_o, op_i,         | to block
//           | position_i, value_i                  |
//   out     | out_valid_o/out_ready_i, data_out_o, | from block
//           | status_o, count_o                    |
//
// One operation at a time; the entry RAM gives one write and one registered
// read per cycle, and shifts step the shared cursor unit. Clear and rejected
// ops go straight to done; push, replace: write; pop, read, read_top: read,
// then capture; insert: shift up, write; remove: read, capture, shift down.
// Reset clears the count and the sequencer; the RAM needs no clearing pass.
// A new transfer is taken while the previous result waits in the output
// register; the finished op then holds until that register frees up.
module indexed_list_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ile_pkg::OP_W-1:0]         op_i,
  input  logic [ile_pkg::POS_W-1:0]        position_i,
  input  logic [ile_pkg::VALUE_W-1:0]      value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ile_pkg::DATA_OUT_W-1:0]   data_out_o,
  output logic [ile_pkg::STATUS_W-1:0]     status_o,
  output logic [ile_pkg::COUNT_W-1:0]      count_o
);

  ile_pkg::ram_req_t                ram_req;
  logic [ile_pkg::DATA_W-1:0]       ram_rdata;
  ile_pkg::result_t                 res;
  logic                             done, res_take;

  // Output register state
  logic                             out_valid_q, out_valid_d;
  logic [ile_pkg::DATA_OUT_W-1:0]   data_out_q, data_out_d;
  logic [ile_pkg::STATUS_W-1:0]     status_q, status_d;
  logic [ile_pkg::COUNT_W-1:0]      count_q, count_d;

  ile_ram #(
    .WIDTH(ile_pkg::DATA_W),
    .DEPTH(ile_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

  ile_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .position_i (position_i),
    .value_i    (value_i),
    .ram_req_o  (ram_req),
    .ram_rdata_i(ram_rdata),
    .done_o     (done),
    .res_take_i (res_take),
    .res_o      (res)
  );

  // Result moves into the output register when it is empty or draining
  assign res_take = done && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    data_out_d  = data_out_q;
    status_d    = status_q;
    count_d     = count_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_take) begin
      out_valid_d = 1'b1;
      data_out_d  = ile_pkg::DATA_OUT_W'(res.data);
      status_d    = res.status;
      count_d     = ile_pkg::COUNT_W'(res.count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_out_q <= data_out_d;
    status_q   <= status_d;
    count_q    <= count_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

endmodule

### test/indexed_list_engine_tb.sv
// Self-checking testbench for indexed_list_engine: directed corner cases, fill and drain
// rounds and a random operation mix, all checked against a shadow list kept in the bench.
// Depends on ile_pkg and the indexed_list_engine RTL.
module indexed_list_engine_tb;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 64;
  localparam int SHOW_ERRORS  = 10;

  // One result as it leaves the block, at port widths
  typedef struct packed {
    logic [ile_pkg::DATA_OUT_W-1:0] data;
    ile_pkg::status_e               status;
    logic [ile_pkg::COUNT_W-1:0]    count;
  } list_result_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic [ile_pkg::OP_W-1:0]       op_q      = ile_pkg::OP_PUSH;
  logic [ile_pkg::POS_W-1:0]      pos_q     = '0;
  logic [ile_pkg::VALUE_W-1:0]    value_q   = '0;
  logic                           out_ready = 1'b0;

  logic                           in_ready;
  logic                           out_valid;
  logic [ile_pkg::DATA_OUT_W-1:0] data_out;
  logic [ile_pkg::STATUS_W-1:0]   status;
  logic [ile_pkg::COUNT_W-1:0]    count;

  // Shadow copy of the list contents
  logic [ile_pkg::DATA_W-1:0]     shadow_entries [ile_pkg::DEPTH];
  int                             shadow_count = 0;

  list_result_t                   pending_results [$];

  bit                             idle_on     = 1'b0;
  int                             ready_hold  = 0;
  int                             cycles      = 0;
  int                             errors      = 0;
  int                             items_sent  = 0;
  int                             results_ok  = 0;
  int                             full_hits   = 0;
  int                             range_hits  = 0;
  int                             op_hits [8];

  indexed_list_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op_q),
    .position_i  (pos_q),
    .value_i     (value_q),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_out_o  (data_out),
    .status_o    (status),
    .count_o     (count)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- shadow list
  function automatic void shadow_insert(int at, logic [ile_pkg::DATA_W-1:0] val);
    for (int i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[at] = val;
    shadow_count++;
  endfunction

  function automatic logic [ile_pkg::DATA_W-1:0] shadow_remove(int at);
    logic [ile_pkg::DATA_W-1:0] v;
    v = shadow_entries[at];
    for (int i = at; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
    shadow_count--;
    return v;
  endfunction

  // Applies one operation to the shadow list and returns the result it should give
  function automatic list_result_t list_apply(ile_pkg::op_e opc,
                                              logic [ile_pkg::POS_W-1:0] pos,
                                              logic [ile_pkg::VALUE_W-1:0] val);
    list_result_t r;
    int           p;
    r.data   = '0;
    r.status = ile_pkg::STAT_OK;
    p        = int'(pos);
    case (opc)
      ile_pkg::OP_PUSH: begin
        if (shadow_count >= ile_pkg::DEPTH) r.status = ile_pkg::STAT_FULL;
        else shadow_insert(shadow_count, val[ile_pkg::DATA_W-1:0]);
      end
      ile_pkg::OP_POP: begin
        if (shadow_count == 0) r.status = ile_pkg::STAT_EMPTY;
        else r.data = ile_pkg::DATA_OUT_W'(shadow_remove(shadow_count - 1));
      end
      ile_pkg::OP_INSERT: begin
        // a position past the end appends
        if (p > shadow_count) p = shadow_count;
        if (shadow_count >= ile_pkg::DEPTH) r.status = ile_pkg::STAT_FULL;
        else shadow_insert(p, val[ile_pkg::DATA_W-1:0]);
      end
      ile_pkg::OP_REMOVE: begin
        if (p >= shadow_count) r.status = ile_pkg::STAT_EMPTY;
        else r.data = ile_pkg::DATA_OUT_W'(shadow_remove(p));
      end
      ile_pkg::OP_REPLACE: begin
        if (p >= shadow_count) r.status = ile_pkg::STAT_EMPTY;
        else shadow_entries[p] = val[ile_pkg::DATA_W-1:0];
      end
      ile_pkg::OP_READ: begin
        if (p >= shadow_count) r.status = ile_pkg::STAT_EMPTY;
        else r.data = ile_pkg::DATA_OUT_W'(shadow_entries[p]);
      end
      ile_pkg::OP_TOP: begin
        if (shadow_count == 0) r.status = ile_pkg::STAT_EMPTY;
        else r.data = ile_pkg::DATA_OUT_W'(shadow_entries[shadow_count - 1]);
      end
      ile_pkg::OP_CLEAR: shadow_count = 0;
    endcase
    r.count = ile_pkg::COUNT_W'(shadow_count);
    if (r.status == ile_pkg::STAT_FULL) full_hits++;
    if (r.status == ile_pkg::STAT_EMPTY) range_hits++;
    op_hits[opc]++;
    return r;
  endfunction

  // ---------------------------------------------------------------- random helpers
  // Idle length from three ranges: mostly the shortest, now and then the longest
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(40, 15);
  endfunction

  function automatic logic [ile_pkg::VALUE_W-1:0] rand_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Mostly a valid index for the current fill level, sometimes anything
  function automatic logic [ile_pkg::POS_W-1:0] rand_pos(int span);
    if (span > 0 && $urandom_range(99) < 80)
      return ile_pkg::POS_W'($urandom_range(span - 1));
    return ile_pkg::POS_W'($urandom_range(ile_pkg::DEPTH - 1));
  endfunction

  function automatic ile_pkg::op_e pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 18) return ile_pkg::OP_PUSH;
    if (r < 30) return ile_pkg::OP_POP;
    if (r < 48) return ile_pkg::OP_INSERT;
    if (r < 62) return ile_pkg::OP_REMOVE;
    if (r < 73) return ile_pkg::OP_REPLACE;
    if (r < 88) return ile_pkg::OP_READ;
    if (r < 97) return ile_pkg::OP_TOP;
    return ile_pkg::OP_CLEAR;
  endfunction

  // ---------------------------------------------------------------- receive side
  // Random back-pressure on the result channel
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(99) < 20) ready_hold = gap_len();
    end
  end

  // Each result transfer is checked against the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("unexpected result: data %h status %0d count %0d", data_out, status, count);
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.data || status !== want.status || count !== want.count) begin
          errors++;
          if (errors <= SHOW_ERRORS)
            $display("mismatch: expected data %h status %0d count %0d, got %h %0d %0d",
                     want.data, want.status, want.count, data_out, status, count);
        end else begin
          results_ok++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("indexed_list_engine_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- send side
  // Presents one operation, holds it until the transfer, then maybe idles
  task automatic issue_op(ile_pkg::op_e opc, logic [ile_pkg::POS_W-1:0] pos,
                          logic [ile_pkg::VALUE_W-1:0] val);
    int gap;
    in_valid <= 1'b1;
    op_q     <= opc;
    pos_q    <= pos;
    value_q  <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(list_apply(opc, pos, val));
    items_sent++;
    gap = (idle_on && $urandom_range(99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result is back
  task automatic await_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // everything on an empty list is rejected
    issue_op(ile_pkg::OP_POP,     4'd0,  '0);
    issue_op(ile_pkg::OP_TOP,     4'd0,  '0);
    issue_op(ile_pkg::OP_READ,    4'd0,  '0);
    issue_op(ile_pkg::OP_REMOVE,  4'd15, '0);
    issue_op(ile_pkg::OP_REPLACE, 4'd0,  32'h1234_5678);
    // value extremes, insert past the end lands at the tail
    issue_op(ile_pkg::OP_PUSH,    4'd15, 32'hFFFF_FFFF);
    issue_op(ile_pkg::OP_PUSH,    4'd0,  32'h0000_0000);
    issue_op(ile_pkg::OP_INSERT,  4'd15, 32'hAAAA_5555);
    issue_op(ile_pkg::OP_INSERT,  4'd0,  32'h5555_AAAA);
    issue_op(ile_pkg::OP_READ,    4'd3,  '0);
    issue_op(ile_pkg::OP_READ,    4'd4,  '0);
    issue_op(ile_pkg::OP_REPLACE, 4'd1,  32'h8000_0001);
    issue_op(ile_pkg::OP_REPLACE, 4'd15, 32'h7FFF_FFFE);
    issue_op(ile_pkg::OP_REMOVE,  4'd0,  '0);
    issue_op(ile_pkg::OP_REMOVE,  4'd15, '0);
    issue_op(ile_pkg::OP_TOP,     4'd0,  '0);
    issue_op(ile_pkg::OP_POP,     4'd0,  '0);
    // clear keeps data but hides it
    issue_op(ile_pkg::OP_CLEAR,   4'd9,  32'hFFFF_FFFF);
    issue_op(ile_pkg::OP_TOP,     4'd0,  '0);
    issue_op(ile_pkg::OP_READ,    4'd0,  '0);
    issue_op(ile_pkg::OP_PUSH,    4'd0,  32'hDEAD_BEEF);
    issue_op(ile_pkg::OP_READ,    4'd0,  '0);
  endtask

  // Fill to capacity, poke at a full list, then empty it again
  task automatic test_fill_drain(int rounds);
    repeat (rounds) begin
      while (shadow_count < ile_pkg::DEPTH) begin
        if ($urandom_range(1))
          issue_op(ile_pkg::OP_PUSH, rand_pos(ile_pkg::DEPTH), rand_value());
        else issue_op(ile_pkg::OP_INSERT, rand_pos(shadow_count + 1), rand_value());
        if ($urandom_range(99) < 15)
          issue_op(ile_pkg::OP_READ, rand_pos(shadow_count), '0);
      end
      issue_op(ile_pkg::OP_PUSH,    rand_pos(ile_pkg::DEPTH), rand_value());
      issue_op(ile_pkg::OP_INSERT,  rand_pos(ile_pkg::DEPTH), rand_value());
      issue_op(ile_pkg::OP_READ,    4'd15, '0);
      issue_op(ile_pkg::OP_REPLACE, 4'd15, rand_value());
      issue_op(ile_pkg::OP_TOP,     4'd0,  '0);
      while (shadow_count > 0) begin
        if ($urandom_range(1))
          issue_op(ile_pkg::OP_POP, rand_pos(ile_pkg::DEPTH), rand_value());
        else issue_op(ile_pkg::OP_REMOVE, rand_pos(shadow_count), rand_value());
        if ($urandom_range(99) < 15)
          issue_op(ile_pkg::OP_TOP, rand_pos(ile_pkg::DEPTH), '0);
      end
      issue_op(ile_pkg::OP_POP,    4'd0, '0);
      issue_op(ile_pkg::OP_REMOVE, 4'd0, '0);
    end
  endtask

  // Free mix of all operations; positions follow the fill level most of the time
  task automatic test_random_mix(int n);
    ile_pkg::op_e opc;
    for (int k = 0; k < n; k++) begin
      opc = pick_op();
      if (opc == ile_pkg::OP_INSERT) issue_op(opc, rand_pos(shadow_count + 1), rand_value());
      else issue_op(opc, rand_pos(shadow_count), rand_value());
      if (k % 150 == 149) await_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b0;
    test_directed();
    await_drain();

    idle_on = 1'b1;
    test_fill_drain(6);
    await_drain();

    idle_on = 1'b0;
    test_fill_drain(3);
    await_drain();

    idle_on = 1'b1;
    test_random_mix(700);
    await_drain();

    idle_on = 1'b0;
    test_random_mix(350);
    await_drain();

    idle_on = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operations sent, %0d results matched (push %0d pop %0d insert %0d",
             items_sent, results_ok, op_hits[ile_pkg::OP_PUSH], op_hits[ile_pkg::OP_POP],
             op_hits[ile_pkg::OP_INSERT]);
    $display("  remove %0d replace %0d read %0d top %0d clear %0d), %0d full and %0d range",
             op_hits[ile_pkg::OP_REMOVE], op_hits[ile_pkg::OP_REPLACE],
             op_hits[ile_pkg::OP_READ], op_hits[ile_pkg::OP_TOP],
             op_hits[ile_pkg::OP_CLEAR], full_hits, range_hits);
    if (errors == 0) begin
      $display("indexed_list_engine_tb passed");
    end else begin
      $display("indexed_list_engine_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ile_pkg.sv
hdl/ile_ram.sv
hdl/ile_ctl.sv
hdl/indexed_list_engine.sv
test/indexed_list_engine_tb.sv
